[hw/rtl/isq_pkg.sv]
// Shared types and constants for the indexed sequence store.
// Used by isq_cell and indexed_sequence_store; depends on nothing.
package isq_pkg;

	localparam int OP_W       = 2;
	localparam int POS_W      = 6;
	localparam int DATA_W     = 32;
	localparam int STATUS_W   = 2;
	localparam int COUNT_O_W  = 7;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 2'd0,
		OP_DELETE = 2'd1,
		OP_GET    = 2'd2,
		OP_SET    = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE     = 2'd0,
		ST_PAST_END = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_READ = 2'd1,
		S_HOLD = 2'd2
	} state_t;

	// Broadcast command to every cell of the chain
	typedef struct packed {
		logic app;
		logic set;
		logic del;
		logic rd_load;
		logic rd_shift;
	} cell_op_t;

endpackage

[hw/rtl/isq_cell.sv]
// One storage cell of the sequence chain: an entry and a read-lane stage.
// Depends on isq_pkg.
module isq_cell
	import isq_pkg::*;
#(
	parameter int INDEX       = 0,
	parameter int VALUE_WIDTH = 32,
	parameter int CNT_W       = 7
) (
	input  logic                   clk,
	input  cell_op_t               cmd,
	input  logic [POS_W-1:0]       position,
	input  logic [CNT_W-1:0]       count,
	input  logic [VALUE_WIDTH-1:0] wdata,
	input  logic [VALUE_WIDTH-1:0] nb_entry,
	input  logic [VALUE_WIDTH-1:0] nb_rd,
	output logic [VALUE_WIDTH-1:0] entry,
	output logic [VALUE_WIDTH-1:0] rd
);

	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	logic [CMP_W-1:0]       idx;
	logic [CMP_W-1:0]       pos_ext;
	logic [CMP_W-1:0]       cnt_ext;
	logic                   at_pos;
	logic                   at_end;
	logic                   above;
	logic [VALUE_WIDTH-1:0] entry_q;
	logic [VALUE_WIDTH-1:0] rd_q;

	assign idx     = CMP_W'(INDEX);
	assign pos_ext = CMP_W'(position);
	assign cnt_ext = CMP_W'(count);
	assign at_pos  = (idx == pos_ext);
	assign at_end  = (idx == cnt_ext);
	assign above   = (idx >= pos_ext);

	// entry: append at the tail, overwrite in place, or pull from the next cell
	always_ff @(posedge clk) begin
		if (cmd.app && at_end) begin
			entry_q <= wdata;
		end else if (cmd.set && at_pos) begin
			entry_q <= wdata;
		end else if (cmd.del && above) begin
			entry_q <= nb_entry;
		end
	end

	// read lane: snapshot the entry, then hand towards cell 0
	always_ff @(posedge clk) begin
		if (cmd.rd_load) begin
			rd_q <= entry_q;
		end else if (cmd.rd_shift) begin
			rd_q <= nb_rd;
		end
	end

	assign entry = entry_q;
	assign rd    = rd_q;

endmodule

[hw/rtl/indexed_sequence_store.sv]
// Indexed sequence store: a row of CAPACITY cells holding an ordered list.
// Append, delete, set and a get past the end answer through the registered response;
// one such request is taken every cycle while the response side keeps up.
// A get at position p first snapshots the entries into the read lane, which then walks
// the snapshot one cell per cycle towards cell 0. Reset clears the state, the count and
// the response valid flag; the entries and the response payload are not cleared.
module indexed_sequence_store
	import isq_pkg::*;
#(
	parameter int CAPACITY    = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// request channel
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic [OP_W-1:0]             op,
	input  logic [POS_W-1:0]            position,
	input  logic signed [DATA_W-1:0]    value,
	// response channel
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic signed [DATA_W-1:0]    read_value,
	output logic [STATUS_W-1:0]         status,
	output logic [COUNT_O_W-1:0]        count
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	// control state
	state_t               state_q, state_d;
	logic [CNT_W-1:0]     cnt_q, cnt_d;
	logic [POS_W-1:0]     rcnt_q;
	status_t              pend_status_q;
	logic                 rsp_valid_q;
	logic [DATA_W-1:0]    read_value_q;
	logic [STATUS_W-1:0]  status_q;
	logic [COUNT_O_W-1:0] count_q;

	// combinational decisions
	logic                 accept;
	logic                 out_free;
	logic                 full;
	logic                 past_end;
	cell_op_t             cmd;
	logic                 rsp_load;
	logic                 pend_load;
	logic                 rcnt_load;
	logic [DATA_W-1:0]    res_value;
	status_t              res_status;

	// data path
	logic [63:0]            value_ext;
	logic [VALUE_WIDTH-1:0] wdata;
	logic [63:0]            rd0_ext;
	logic [VALUE_WIDTH-1:0] entry_w [CAPACITY];
	logic [VALUE_WIDTH-1:0] rd_w    [CAPACITY];

	assign accept   = req_valid && !req_stall;
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign full     = (cnt_q == CNT_W'(CAPACITY));
	assign past_end = (CMP_W'(position) >= CMP_W'(cnt_q));

	// sign-extend the request value, keep the stored width
	assign value_ext = {{32{value[DATA_W-1]}}, value};
	assign wdata     = value_ext[VALUE_WIDTH-1:0];

	// cell 0's read lane holds the fetched entry; return its low 32 bits
	assign rd0_ext = 64'(rd_w[0]);

	// take no new request while a get walks the lane or a result is parked
	assign req_stall = (state_q != S_IDLE);

	// ------------------------------------------------------------------
	// next state and cell commands
	// ------------------------------------------------------------------
	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		cmd        = '0;
		rsp_load   = 1'b0;
		pend_load  = 1'b0;
		rcnt_load  = 1'b0;
		res_value  = '1;
		res_status = ST_DONE;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (op_t'(op))
						OP_APPEND: begin
							if (full) begin
								res_status = ST_FULL;
							end else begin
								cmd.app = 1'b1;
								cnt_d   = cnt_q + CNT_W'(1);
							end
						end
						OP_DELETE: begin
							if (past_end) begin
								res_status = ST_PAST_END;
							end else begin
								cmd.del = 1'b1;
								cnt_d   = cnt_q - CNT_W'(1);
							end
						end
						OP_GET: begin
							if (past_end) begin
								res_status = ST_PAST_END;
							end else begin
								cmd.rd_load = 1'b1;
								rcnt_load   = 1'b1;
							end
						end
						OP_SET: begin
							if (past_end) begin
								res_status = ST_PAST_END;
							end else begin
								cmd.set = 1'b1;
							end
						end
						default: begin
						end
					endcase
					// every request but a hitting get answers now if the output is free, else parks in S_HOLD
					if (rcnt_load) begin
						state_d = S_READ;
					end else if (out_free) begin
						rsp_load = 1'b1;
					end else begin
						pend_load = 1'b1;
						state_d   = S_HOLD;
					end
				end
			end
			S_READ: begin
				if (rcnt_q == '0) begin
					res_value = rd0_ext[DATA_W-1:0];
					if (out_free) begin
						rsp_load = 1'b1;
						state_d  = S_IDLE;
					end
				end else begin
					cmd.rd_shift = 1'b1;
				end
			end
			S_HOLD: begin
				res_status = pend_status_q;
				if (out_free) begin
					rsp_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// lane walk counter: load the position, count down as the lane advances
	always_ff @(posedge clk) begin
		if (rcnt_load) begin
			rcnt_q <= position;
		end else if (cmd.rd_shift) begin
			rcnt_q <= rcnt_q - POS_W'(1);
		end
	end

	// park the status of a result that found the response register busy
	always_ff @(posedge clk) begin
		if (pend_load) begin
			pend_status_q <= res_status;
		end
	end

	// response payload; count is the count after the request
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			read_value_q <= res_value;
			status_q     <= res_status;
			count_q      <= COUNT_O_W'(cnt_d);
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign read_value = read_value_q;
	assign status     = status_q;
	assign count      = count_q;

	// ------------------------------------------------------------------
	// chain of cells; each below the top takes its upper neighbour's entry and lane
	// ------------------------------------------------------------------
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VALUE_WIDTH-1:0] nb_entry;
		logic [VALUE_WIDTH-1:0] nb_rd;
		if (i == CAPACITY - 1) begin : g_top
			assign nb_entry = entry_w[i];
			assign nb_rd    = rd_w[i];
		end else begin : g_mid
			assign nb_entry = entry_w[i+1];
			assign nb_rd    = rd_w[i+1];
		end
		isq_cell #(
			.INDEX       (i),
			.VALUE_WIDTH (VALUE_WIDTH),
			.CNT_W       (CNT_W)
		) u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.position (position),
			.count    (cnt_q),
			.wdata    (wdata),
			.nb_entry (nb_entry),
			.nb_rd    (nb_rd),
			.entry    (entry_w[i]),
			.rd       (rd_w[i])
		);
	end

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("entry count beyond capacity");

	a_hold_needs_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HOLD) |-> rsp_valid_q)
		else $error("result parked while response register free");

	a_full_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (op_t'(op) == OP_APPEND) && full) |=> $stable(cnt_q))
		else $error("dropped append changed the count");

	a_full_status_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (status_q == ST_FULL)) |-> (count_q == COUNT_O_W'(CAPACITY)))
		else $error("full status with count below capacity");

endmodule
